FILE: rtl/bma_pkg.sv
// Package for the buddy memory allocator.
// Node status codes, node word layout, opcodes and field widths.
// No dependencies.
package bma_pkg;

	// default memory size in allocation units (power of two)
	localparam int MEM_UNITS_DEF = 1024;

	// fixed field widths of the stream payload
	localparam int PID_W  = 16;
	localparam int SIZE_W = 16;
	localparam int ADDR_W = 10;

	// request kinds carried on tuser
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// tree node status
	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_SPLIT = 2'd1,
		ST_OWNED = 2'd2
	} node_st_t;

	// one tree node as kept in the node store
	typedef struct packed {
		logic [PID_W-1:0] owner;
		node_st_t         st;
	} node_t;

	localparam int NODE_W = $bits(node_t);

endpackage

FILE: rtl/bma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the allocator's node store. No dependencies.
module bma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/buddy_memory_allocator_top.sv
// Binary buddy allocator over MEM_UNITS units. Each request (allocate by size, or free by
// owner id) is one input transaction and gives exactly one result transaction. The tree is
// walked in left-first depth order, each node read and then evaluated, descending only
// through split nodes; an allocation splits nodes level by level down to its target, and a
// free merges free buddies level by level upward. A zero-size or oversize allocate skips
// the walk. One request is in flight at a time; a new request is accepted while the previous
// result still waits on the output. The root node sits in a register that reset marks free;
// all other nodes live in a RAM that needs no clearing, since a node is only read once its
// parent has been split, and splitting always writes both children. Depends on bma_pkg.
module buddy_memory_allocator_top import bma_pkg::*; #(
	parameter int MEM_UNITS = MEM_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] process_id, [31:16] request_size
	input  logic [0:0]  s_axis_tuser,  // [0] op
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [0] ok, [1] block_valid, [11:2] block_start,
	                                   // [21:12] block_end, [23:22] zero
);

	localparam int LVL       = $clog2(MEM_UNITS);
	localparam int D_W       = $clog2(LVL + 1);
	localparam int RAM_DEPTH = 2 * MEM_UNITS - 2;
	localparam int A_W       = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam logic [16:0] MEM_SZ   = 17'(MEM_UNITS);
	localparam logic [16:0] MEM_MASK = 17'(MEM_UNITS - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_EVAL,
		S_SPLIT,
		S_RFREE,
		S_OWN,
		S_REL,
		S_MRD,
		S_MEV,
		S_DONE
	} state_t;

	state_t              state_q;
	logic                op_q;
	logic [PID_W-1:0]    pid_q;
	logic [D_W-1:0]      dw_q;
	logic [D_W-1:0]      d_q;
	logic [LVL-1:0]      p_q;
	logic                rd_root_s1;
	node_t               root_q;
	logic                res_ok_q, res_bv_q;
	logic [ADDR_W-1:0]   res_start_q, res_end_q;
	logic                out_valid_q;
	logic [23:0]         out_data_q;

	// input fields
	logic                in_op;
	logic [PID_W-1:0]    in_pid;
	logic [SIZE_W-1:0]   in_size;
	logic                in_acc;
	logic                out_free;

	assign in_op   = s_axis_tuser[0];
	assign in_pid  = s_axis_tdata[15:0];
	assign in_size = s_axis_tdata[31:16];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// target depth of an allocation: depth of the smallest power of two covering the size
	logic [4:0]     k_log;
	logic [D_W-1:0] dw_n;
	logic           oversize;
	always_comb begin
		k_log = 5'd16;
		for (int i = 16; i >= 0; i--) begin
			if (17'(in_size) <= (17'd1 << i)) begin
				k_log = 5'(i);
			end
		end
		dw_n     = D_W'(LVL - int'(k_log));
		oversize = (17'(in_size) > MEM_SZ);
	end

	// node addressing: RAM holds nodes 1.., address is heap index minus one
	logic [LVL:0]   one_d;
	logic [LVL-1:0] p_eff;
	logic [LVL:0]   addr_full;
	logic [A_W-1:0] ram_addr;
	always_comb begin
		one_d     = (LVL + 1)'(1) << d_q;
		p_eff     = (state_q == S_MRD) ? (p_q ^ LVL'(1)) : p_q;
		addr_full = one_d - (LVL + 1)'(2) + (LVL + 1)'(p_eff);
		ram_addr  = addr_full[A_W-1:0];
	end

	// node store
	logic             ram_we, ram_re, root_we;
	node_t            wr_node;
	logic [NODE_W-1:0] ram_rdata;
	node_t            rd_node;
	logic             wr_state;

	always_comb begin
		wr_node.owner = pid_q;
		wr_node.st    = ST_FREE;
		wr_state      = 1'b0;
		unique case (state_q)
			S_SPLIT: begin
				wr_node.st = ST_SPLIT;
				wr_state   = 1'b1;
			end
			S_RFREE, S_REL: begin
				wr_node.st = ST_FREE;
				wr_state   = 1'b1;
			end
			S_OWN: begin
				wr_node.st = ST_OWNED;
				wr_state   = 1'b1;
			end
			default: begin
				wr_state = 1'b0;
			end
		endcase
		ram_we  = wr_state && (d_q != '0);
		root_we = wr_state && (d_q == '0);
		ram_re  = ((state_q == S_RD) && (d_q != '0)) || (state_q == S_MRD);
	end

	bma_ram #(
		.WIDTH(NODE_W),
		.DEPTH(RAM_DEPTH)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(wr_node),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	assign rd_node = rd_root_s1 ? root_q : node_t'(ram_rdata);

	// next node in left-first depth order once the current subtree is done
	logic [LVL:0]   q_nxt;
	logic [D_W-1:0] tz;
	logic           walk_end;
	logic [D_W-1:0] adv_d;
	logic [LVL-1:0] adv_p;
	always_comb begin
		q_nxt = (LVL + 1)'(p_q) + (LVL + 1)'(1);
		tz    = '0;
		for (int i = LVL - 1; i >= 0; i--) begin
			if (q_nxt[i]) begin
				tz = D_W'(i);
			end
		end
		walk_end = (q_nxt == one_d);
		adv_d    = d_q - tz;
		adv_p    = LVL'(q_nxt >> tz);
	end

	// block bounds of the current node
	logic [16:0] blk_start, blk_end;
	always_comb begin
		blk_start = 17'(p_q) << (D_W'(LVL) - d_q);
		blk_end   = blk_start | (MEM_MASK >> d_q);
	end

	logic own_hit;
	assign own_hit = (rd_node.st == ST_OWNED) && (rd_node.owner == pid_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			root_q.st    <= ST_FREE;
			root_q.owner <= '0;
			rd_root_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
			op_q         <= OP_ALLOC;
			pid_q        <= '0;
			dw_q         <= '0;
			d_q          <= '0;
			p_q          <= '0;
			res_ok_q     <= 1'b0;
			res_bv_q     <= 1'b0;
			res_start_q  <= '0;
			res_end_q    <= '0;
			out_data_q   <= '0;
		end else begin
			if (root_we) begin
				root_q <= wr_node;
			end
			// result taken; a new one is loaded in S_DONE instead
			if (m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q        <= in_op;
						pid_q       <= in_pid;
						dw_q        <= dw_n;
						d_q         <= '0;
						p_q         <= '0;
						res_ok_q    <= 1'b0;
						res_bv_q    <= 1'b0;
						res_start_q <= '0;
						res_end_q   <= '0;
						if (in_op == OP_ALLOC && in_size == '0) begin
							res_ok_q <= 1'b1;
							state_q  <= S_DONE;
						end else if (in_op == OP_ALLOC && oversize) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					rd_root_s1 <= (d_q == '0);
					state_q    <= S_EVAL;
				end
				S_EVAL: begin
					priority if (op_q == OP_FREE && own_hit) begin
						state_q <= S_REL;
					end else if (op_q == OP_FREE && rd_node.st == ST_SPLIT &&
						d_q != D_W'(LVL)) begin
						d_q     <= d_q + D_W'(1);
						p_q     <= p_q << 1;
						state_q <= S_RD;
					end else if (op_q == OP_ALLOC && d_q == dw_q &&
						rd_node.st == ST_FREE) begin
						state_q <= S_OWN;
					end else if (op_q == OP_ALLOC && d_q != dw_q &&
						rd_node.st == ST_FREE) begin
						state_q <= S_SPLIT;
					end else if (op_q == OP_ALLOC && d_q != dw_q &&
						rd_node.st == ST_SPLIT) begin
						d_q     <= d_q + D_W'(1);
						p_q     <= p_q << 1;
						state_q <= S_RD;
					end else if (walk_end) begin
						state_q <= S_DONE;
					end else begin
						d_q     <= adv_d;
						p_q     <= adv_p;
						state_q <= S_RD;
					end
				end
				S_SPLIT: begin
					// node becomes split; move to its right child
					d_q     <= d_q + D_W'(1);
					p_q     <= (p_q << 1) | LVL'(1);
					state_q <= S_RFREE;
				end
				S_RFREE: begin
					// right child cleared; continue with the left child
					p_q     <= p_q & ~LVL'(1);
					state_q <= (d_q == dw_q) ? S_OWN : S_SPLIT;
				end
				S_OWN: begin
					res_ok_q    <= 1'b1;
					res_bv_q    <= 1'b1;
					res_start_q <= blk_start[ADDR_W-1:0];
					res_end_q   <= blk_end[ADDR_W-1:0];
					state_q     <= S_DONE;
				end
				S_REL: begin
					res_ok_q <= 1'b1;
					state_q  <= (d_q == '0) ? S_DONE : S_MRD;
				end
				S_MRD: begin
					rd_root_s1 <= 1'b0;
					state_q    <= S_MEV;
				end
				S_MEV: begin
					// buddy free too: merge into the parent
					if (rd_node.st == ST_FREE) begin
						d_q     <= d_q - D_W'(1);
						p_q     <= p_q >> 1;
						state_q <= S_REL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, res_end_q, res_start_q, res_bv_q, res_ok_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("node store read and written in one cycle");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		d_q <= D_W'(LVL))
		else $error("walk depth beyond leaf level");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("request taken without starting work");

	a_block_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[0] &&
		m_axis_tdata[21:12] >= m_axis_tdata[11:2]))
		else $error("assigned block with bad flags or bounds");

	a_split_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> (d_q < dw_q))
		else $error("split at or below target depth");

endmodule

FILE: dv/tb.sv
// Testbench for buddy_memory_allocator_top: directed and random allocate/free traffic,
// checked against an in-bench buddy tree predictor held in a scoreboard class.
// Depends on bma_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;
	import bma_pkg::*;

	localparam int UNITS    = MEM_UNITS_DEF;
	localparam int NODES    = 2 * UNITS - 1;
	localparam int WDOG_LIM = 40 * UNITS + 20000;

	// result word layout, lowest bits last
	typedef struct packed {
		logic [ADDR_W-1:0] blk_end;
		logic [ADDR_W-1:0] blk_start;
		logic              blk_vld;
		logic              ok;
	} alloc_res_t;

	// buddy tree predictor plus queue of pending results
	class alloc_scoreboard;
		node_st_t       st [NODES];
		logic [15:0]    own [NODES];
		alloc_res_t     pending [$];
		int             fails;

		function new();
			foreach (st[i]) st[i] = ST_FREE;
			fails = 0;
		endfunction

		function automatic bit place_blk(int idx, int start, int sz, int want,
				logic [15:0] pid, ref int got);
			if (idx >= NODES) return 0;
			if (st[idx] == ST_OWNED) return 0;
			if (sz == want) begin
				if (st[idx] != ST_FREE) return 0;
				st[idx] = ST_OWNED;
				own[idx] = pid;
				got = start;
				return 1;
			end
			if (sz < 2) return 0;
			if (st[idx] == ST_FREE) begin
				st[idx] = ST_SPLIT;
				st[2*idx+1] = ST_FREE;
				st[2*idx+2] = ST_FREE;
			end
			if (place_blk(2*idx+1, start, sz/2, want, pid, got)) return 1;
			return place_blk(2*idx+2, start + sz/2, sz/2, want, pid, got);
		endfunction

		function automatic int find_pid(int idx, int sz, logic [15:0] pid);
			int h;
			if (idx >= NODES) return -1;
			if (st[idx] == ST_OWNED) return (own[idx] == pid) ? idx : -1;
			if (st[idx] != ST_SPLIT || sz < 2) return -1;
			h = find_pid(2*idx+1, sz/2, pid);
			if (h >= 0) return h;
			return find_pid(2*idx+2, sz/2, pid);
		endfunction

		// accepted request: compute and queue its result
		function void note_req(logic op, logic [15:0] pid, logic [15:0] req);
			alloc_res_t r;
			int want, got, hit, par;
			r = '0;
			if (op == OP_ALLOC) begin
				if (req == 0) r.ok = 1'b1;
				else if (req <= UNITS) begin
					want = 1;
					got = 0;
					while (want < req) want = want * 2;
					if (place_blk(0, 0, UNITS, want, pid, got)) begin
						r.ok = 1'b1;
						r.blk_vld = 1'b1;
						r.blk_start = got[ADDR_W-1:0];
						r.blk_end = ADDR_W'(got + want - 1);
					end
				end
			end else begin
				hit = find_pid(0, UNITS, pid);
				if (hit >= 0) begin
					st[hit] = ST_FREE;
					// merge free buddies upward
					while (hit > 0) begin
						par = (hit - 1) / 2;
						if (st[2*par+1] == ST_FREE && st[2*par+2] == ST_FREE) begin
							st[par] = ST_FREE;
							hit = par;
						end else break;
					end
					r.ok = 1'b1;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_res(logic [23:0] d);
			alloc_res_t e, a;
			a = d[21:0];
			if (pending.size() == 0) begin
				$error("unexpected result transaction %h", d);
				fails++;
				return;
			end
			e = pending.pop_front();
			if (a.ok !== e.ok) begin
				$error("ok exp %0d got %0d", e.ok, a.ok); fails++;
			end
			if (a.blk_vld !== e.blk_vld) begin
				$error("block_valid exp %0d got %0d", e.blk_vld, a.blk_vld); fails++;
			end
			if (a.blk_start !== e.blk_start) begin
				$error("block_start exp %0d got %0d", e.blk_start, a.blk_start); fails++;
			end
			if (a.blk_end !== e.blk_end) begin
				$error("block_end exp %0d got %0d", e.blk_end, a.blk_end); fails++;
			end
			if (d[23:22] !== 2'b00) begin
				$error("pad exp 0 got %0d", d[23:22]); fails++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;

	int  src_idle_pct = 14;
	int  snk_idle_pct = 53;
	int  hold_cycles = 0;
	int  wdog = 0;
	bit  stim_done = 0;
	logic [15:0] live_pids [$];
	alloc_scoreboard sb;

	buddy_memory_allocator_top DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: random stall, plus a long hold-off when requested
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_res(m_axis_tdata);
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog > WDOG_LIM) begin
			$display("FAIL buddy_memory_allocator_top");
			$finish;
		end
	end

	task automatic send_req(logic op, logic [15:0] pid, logic [15:0] req);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {req, pid};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_req(op, pid, req);
		if (op == OP_ALLOC) live_pids.push_back(pid);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small sizes, occasionally big; frees mostly target live owners
	task automatic rand_req();
		logic [15:0] pid, req;
		int k, r;
		r = $urandom_range(99);
		if (r < 50) begin
			k = $urandom_range(99);
			if (k < 70) req = 16'($urandom_range(16, 1));
			else if (k < 92) req = 16'($urandom_range(128, 17));
			else if (k < 97) req = 16'($urandom_range(UNITS, 129));
			else req = 16'($urandom());
			pid = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(31));
			send_req(OP_ALLOC, pid, req);
		end else if (r < 92 && live_pids.size() > 0) begin
			k = $urandom_range(live_pids.size() - 1);
			pid = live_pids[k];
			live_pids.delete(k);
			send_req(OP_FREE, pid, 16'($urandom()));
		end else
			send_req(OP_FREE, 16'($urandom()), 16'($urandom()));
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes and special cases
		send_req(OP_ALLOC, 16'h0001, 16'd0);
		send_req(OP_ALLOC, 16'h0002, 16'd1025);
		send_req(OP_ALLOC, 16'hFFFF, 16'hFFFF);
		send_req(OP_ALLOC, 16'h0003, 16'd1024);
		send_req(OP_ALLOC, 16'h0004, 16'd1);
		send_req(OP_FREE,  16'h0003, 16'hFFFF);
		send_req(OP_FREE,  16'h0003, 16'd0);
		send_req(OP_ALLOC, 16'hFFFF, 16'd1);
		send_req(OP_ALLOC, 16'hFFFF, 16'd3);
		send_req(OP_ALLOC, 16'h0000, 16'd5);
		send_req(OP_ALLOC, 16'h0005, 16'd512);
		send_req(OP_ALLOC, 16'h0006, 16'd512);
		send_req(OP_FREE,  16'hFFFF, 16'd0);
		send_req(OP_FREE,  16'hFFFF, 16'd0);
		send_req(OP_FREE,  16'h0000, 16'd0);
		send_req(OP_FREE,  16'h0005, 16'd0);
		send_req(OP_FREE,  16'h0006, 16'd0);
		send_req(OP_ALLOC, 16'hAAAA, 16'h5555);
		send_req(OP_ALLOC, 16'h5555, 16'd256);
		send_req(OP_FREE,  16'h1234, 16'hAAAA);
		send_req(OP_FREE,  16'h5555, 16'd0);
		live_pids.delete();

		// three idling phases, with a long receiver hold-off in the first
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin src_idle_pct = 53; snk_idle_pct = 14; end
			if (ph == 2) begin src_idle_pct = 0; snk_idle_pct = 0; end
			if (ph == 0) hold_cycles = 400;
			for (int n = 0; n < 600; n++) rand_req();
		end
		go_idle();
		stim_done = 1;
	end

	// end of run
	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("PASS buddy_memory_allocator_top");
		else
			$display("FAIL buddy_memory_allocator_top");
		$finish;
	end

endmodule
